>>> rtl/core/tcd_pkg.sv
// Shared constants and the result item type for the timed contact debouncer.
// No dependencies; used by every module in rtl/core.
package tcd_pkg;

    localparam int TIME_WIDTH_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;

    // Width of the time and count fields on the result channel
    localparam int OUT_WIDTH = 32;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int DEBOUNCE_WIDTH  = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_TIME = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OPEN_ON_HIGH  = 8'd1;

    typedef struct packed {
        logic                 event_valid;
        logic                 contact_open;
        logic [OUT_WIDTH-1:0] event_time;
        logic [OUT_WIDTH-1:0] transitions;
        logic [OUT_WIDTH-1:0] last_confirm_time;
    } result_t;

endpackage

>>> rtl/core/timed_contact_debouncer.sv
// Top level of the timed contact debouncer: configuration registers, core, output buffer.
// Depends on tcd_pkg, tcd_core and tcd_outbuf.
//
// Usage:
//   s_ channel: one timestamped raw contact sample per item (s_sample_time, s_raw_input).
//   m_ channel: exactly one result item per sample, in order. m_event_valid marks a
//   confirmed transition; m_transitions and m_last_confirm_time are always current.
//   cfg channel: cfg_index 0 writes debounce_time, 1 writes open_on_high; other
//   indexes are ignored. cfg_ready is always high; write only while the block is idle.
// The output buffer registers each result as its sample is accepted, into the skid stage while stalled.
// One item per cycle while s_ready is high; the whole decision is a subtract and compares
// between the accept edge and the result register.
// Reset: aresetn (synchronous, low) clears the debounce state, the transition count
// and both registers; the next sample after reset seeds the levels and confirms nothing.
// Stall: while m_ready is low the result register holds; one more item is taken into
// a skid stage, then s_ready drops until the receiver takes a result.
module timed_contact_debouncer #(
    parameter int TIME_WIDTH  = tcd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = tcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [TIME_WIDTH-1:0]               s_sample_time,
    input  logic                                s_raw_input,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_event_valid,
    output logic                                m_contact_open,
    output logic [tcd_pkg::OUT_WIDTH-1:0]       m_event_time,
    output logic [tcd_pkg::OUT_WIDTH-1:0]       m_transitions,
    output logic [tcd_pkg::OUT_WIDTH-1:0]       m_last_confirm_time,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    logic [tcd_pkg::DEBOUNCE_WIDTH-1:0] debounce_time_reg;
    logic                               open_on_high_reg;
    logic                               s_accept;
    tcd_pkg::result_t                   core_result;
    tcd_pkg::result_t                   out_result;

    assign cfg_ready = 1'b1;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_time_reg <= '0;
            open_on_high_reg  <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                tcd_pkg::REG_DEBOUNCE_TIME: begin
                    debounce_time_reg <= cfg_data[tcd_pkg::DEBOUNCE_WIDTH-1:0];
                end
                tcd_pkg::REG_OPEN_ON_HIGH: begin
                    open_on_high_reg <= cfg_data[0];
                end
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    tcd_core #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .accept        (s_accept),
        .sample_time   (s_sample_time),
        .raw_input     (s_raw_input),
        .debounce_time (debounce_time_reg),
        .open_on_high  (open_on_high_reg),
        .result        (core_result)
    );

    tcd_outbuf u_outbuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (core_result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_result)
    );

    assign m_event_valid       = out_result.event_valid;
    assign m_contact_open      = out_result.contact_open;
    assign m_event_time        = out_result.event_time;
    assign m_transitions       = out_result.transitions;
    assign m_last_confirm_time = out_result.last_confirm_time;

endmodule

>>> rtl/core/tcd_core.sv
// Debounce state and the single-pass decision for one sample item.
// Depends on tcd_pkg (result_t, OUT_WIDTH, DEBOUNCE_WIDTH).
module tcd_core #(
    parameter int TIME_WIDTH  = tcd_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = tcd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              accept,
    input  logic [TIME_WIDTH-1:0]             sample_time,
    input  logic                              raw_input,
    input  logic [tcd_pkg::DEBOUNCE_WIDTH-1:0] debounce_time,
    input  logic                              open_on_high,
    output tcd_pkg::result_t                  result
);

    logic                   seeded_reg,    seeded_next;
    logic                   cand_level_reg, cand_level_next;
    logic [TIME_WIDTH-1:0]  cand_start_reg, cand_start_next;
    logic                   conf_level_reg, conf_level_next;
    logic [COUNT_WIDTH-1:0] total_reg,     total_next;
    logic [TIME_WIDTH-1:0]  last_reg,      last_next;

    logic [TIME_WIDTH-1:0]  held;
    logic                   confirm;
    logic [TIME_WIDTH+tcd_pkg::OUT_WIDTH-1:0]  now_ext;
    logic [TIME_WIDTH+tcd_pkg::OUT_WIDTH-1:0]  last_ext;
    logic [COUNT_WIDTH+tcd_pkg::OUT_WIDTH-1:0] total_ext;

    assign held = sample_time - cand_start_reg;

    // Confirm a held level that differs from the confirmed one
    assign confirm = seeded_reg && (raw_input == cand_level_reg)
                  && (raw_input != conf_level_reg)
                  && (held >= {{(TIME_WIDTH-tcd_pkg::DEBOUNCE_WIDTH){1'b0}}, debounce_time});

    always_comb begin
        seeded_next     = seeded_reg;
        cand_level_next = cand_level_reg;
        cand_start_next = cand_start_reg;
        conf_level_next = conf_level_reg;
        total_next      = total_reg;
        last_next       = last_reg;
        if (!seeded_reg) begin
            seeded_next     = 1'b1;
            cand_level_next = raw_input;
            cand_start_next = sample_time;
            conf_level_next = raw_input;
        end else if (raw_input != cand_level_reg) begin
            // restart the candidate timer
            cand_level_next = raw_input;
            cand_start_next = sample_time;
        end else if (confirm) begin
            conf_level_next = raw_input;
            total_next      = total_reg + COUNT_WIDTH'(1);
            last_next       = sample_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg     <= 1'b0;
            cand_level_reg <= 1'b0;
            cand_start_reg <= '0;
            conf_level_reg <= 1'b0;
            total_reg      <= '0;
            last_reg       <= '0;
        end else if (accept) begin
            seeded_reg     <= seeded_next;
            cand_level_reg <= cand_level_next;
            cand_start_reg <= cand_start_next;
            conf_level_reg <= conf_level_next;
            total_reg      <= total_next;
            last_reg       <= last_next;
        end
    end

    assign now_ext   = {{tcd_pkg::OUT_WIDTH{1'b0}}, sample_time};
    assign last_ext  = {{tcd_pkg::OUT_WIDTH{1'b0}}, last_next};
    assign total_ext = {{tcd_pkg::OUT_WIDTH{1'b0}}, total_next};

    always_comb begin
        result.event_valid       = confirm;
        result.contact_open      = confirm & (open_on_high ? raw_input : ~raw_input);
        result.event_time        = confirm ? now_ext[tcd_pkg::OUT_WIDTH-1:0] : '0;
        result.transitions       = total_ext[tcd_pkg::OUT_WIDTH-1:0];
        result.last_confirm_time = last_ext[tcd_pkg::OUT_WIDTH-1:0];
    end

endmodule

>>> rtl/core/tcd_outbuf.sv
// Result register with a skid stage, so ready toward the source is registered.
// Depends on tcd_pkg (result_t).
module tcd_outbuf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  tcd_pkg::result_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output tcd_pkg::result_t out_data
);

    logic             out_valid_reg;
    logic             skid_valid_reg;
    tcd_pkg::result_t out_data_reg;
    tcd_pkg::result_t skid_data_reg;
    logic             in_accept;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                // drain the skid stage first
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_accept;
            end
        end else if (in_accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (in_accept) begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/tcd_checker.sv
// Port-level checks for the timed contact debouncer, bound to the top level.
// Depends on tcd_pkg (OUT_WIDTH) and timed_contact_debouncer.
module tcd_port_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_event_valid,
    input logic                          m_contact_open,
    input logic [tcd_pkg::OUT_WIDTH-1:0] m_event_time,
    input logic [tcd_pkg::OUT_WIDTH-1:0] m_transitions,
    input logic [tcd_pkg::OUT_WIDTH-1:0] m_last_confirm_time
);

    // Hold a stalled result item
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_valid)
            && $stable(m_contact_open) && $stable(m_event_time)
            && $stable(m_transitions) && $stable(m_last_confirm_time))
        else $error("stalled result item changed");

    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_valid |-> !m_contact_open && (m_event_time == '0))
        else $error("event fields set without an event");

    a_event_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_valid |-> m_last_confirm_time == m_event_time)
        else $error("last confirm time does not match event time");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind timed_contact_debouncer tcd_port_checker u_tcd_checker (.*);

>>> tb/tcd_checker.sv
// Scoreboard for the timed contact debouncer: watches the sample, result and register
// channels, predicts every result item and compares it field by field.
// Depends on tcd_pkg for the register indexes and the result item type.
module tcd_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [tcd_pkg::TIME_WIDTH_DEF-1:0]  s_sample_time,
    input  logic                                s_raw_input,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic                                m_event_valid,
    input  logic                                m_contact_open,
    input  logic [tcd_pkg::OUT_WIDTH-1:0]       m_event_time,
    input  logic [tcd_pkg::OUT_WIDTH-1:0]       m_transitions,
    input  logic [tcd_pkg::OUT_WIDTH-1:0]       m_last_confirm_time,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [tcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Debouncer state as the block should hold it
    bit                                 seeded;
    bit                                 cand_lvl;
    bit [tcd_pkg::TIME_WIDTH_DEF-1:0]   cand_since;
    bit                                 conf_lvl;
    bit [tcd_pkg::COUNT_WIDTH_DEF-1:0]  confirm_count;
    bit [tcd_pkg::TIME_WIDTH_DEF-1:0]   last_confirm_ms;
    bit [tcd_pkg::DEBOUNCE_WIDTH-1:0]   hold_ms;
    bit                                 open_high;

    tcd_pkg::result_t awaited_results[$];

    function automatic tcd_pkg::result_t debounce_predict(
        input bit [tcd_pkg::TIME_WIDTH_DEF-1:0] now,
        input bit                               lvl
    );
        tcd_pkg::result_t               res;
        bit [tcd_pkg::TIME_WIDTH_DEF-1:0] held;
        res  = '0;
        held = now - cand_since;
        if (!seeded) begin
            seeded     = 1'b1;
            cand_lvl   = lvl;
            cand_since = now;
            conf_lvl   = lvl;
        end else if (lvl != cand_lvl) begin
            // restart the timer only, even with a zero hold time
            cand_lvl   = lvl;
            cand_since = now;
        end else if (lvl != conf_lvl && held >= hold_ms) begin
            conf_lvl          = lvl;
            confirm_count     = confirm_count + 1'b1;
            last_confirm_ms   = now;
            res.event_valid   = 1'b1;
            res.contact_open  = open_high ? lvl : ~lvl;
            res.event_time    = now;
        end
        res.transitions       = confirm_count;
        res.last_confirm_time = last_confirm_ms;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : monitor
        tcd_pkg::result_t want;
        if (!aresetn) begin
            seeded          = 1'b0;
            cand_lvl        = 1'b0;
            cand_since      = '0;
            conf_lvl        = 1'b0;
            confirm_count   = '0;
            last_confirm_ms = '0;
            hold_ms         = '0;
            open_high       = 1'b0;
            awaited_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == tcd_pkg::REG_DEBOUNCE_TIME)
                    hold_ms = cfg_data[tcd_pkg::DEBOUNCE_WIDTH-1:0];
                else if (cfg_index == tcd_pkg::REG_OPEN_ON_HIGH)
                    open_high = cfg_data[0];
            end
            // retire before taking a new sample: the result belongs to an older item
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result item with none expected, event_time got %0h",
                             $time, m_event_time);
                end else begin
                    want = awaited_results.pop_front();
                    check_field("event_valid", want.event_valid, m_event_valid);
                    check_field("contact_open", want.contact_open, m_contact_open);
                    check_field("event_time", want.event_time, m_event_time);
                    check_field("transitions", want.transitions, m_transitions);
                    check_field("last_confirm_time", want.last_confirm_time,
                                m_last_confirm_time);
                end
            end
            if (s_valid && s_ready)
                awaited_results.push_back(debounce_predict(s_sample_time, s_raw_input));
        end
        pending = awaited_results.size();
    end

endmodule

>>> tb/tb_top.sv
// Stimulus and verdict for the timed contact debouncer: directed contact sequences,
// then random bounce and hold sequences under several register settings and idle mixes.
// Depends on tcd_pkg, timed_contact_debouncer and tcd_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT       = 200000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 85;

    logic                                aclk;
    logic                                aresetn       = 1'b0;
    logic                                s_valid       = 1'b0;
    logic                                s_ready;
    logic [tcd_pkg::TIME_WIDTH_DEF-1:0]  s_sample_time = '0;
    logic                                s_raw_input   = 1'b0;
    logic                                m_valid;
    logic                                m_ready       = 1'b0;
    logic                                m_event_valid;
    logic                                m_contact_open;
    logic [tcd_pkg::OUT_WIDTH-1:0]       m_event_time;
    logic [tcd_pkg::OUT_WIDTH-1:0]       m_transitions;
    logic [tcd_pkg::OUT_WIDTH-1:0]       m_last_confirm_time;
    logic                                cfg_valid     = 1'b0;
    logic                                cfg_ready;
    logic [tcd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [tcd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data      = '0;

    int        fail_count;
    int        pending;
    int        cycles     = 0;
    int        idle_pct   = 0;
    int        stall_pct  = 0;
    int        db_ms      = 0;
    int        sent_count = 0;
    bit [31:0] now_ms     = '0;
    bit        lvl_guess  = 1'b0;

    timed_contact_debouncer uut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_time      (s_sample_time),
        .s_raw_input        (s_raw_input),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_valid      (m_event_valid),
        .m_contact_open     (m_contact_open),
        .m_event_time       (m_event_time),
        .m_transitions      (m_transitions),
        .m_last_confirm_time(m_last_confirm_time),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    tcd_checker chk (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_time      (s_sample_time),
        .s_raw_input        (s_raw_input),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_valid      (m_event_valid),
        .m_contact_open     (m_contact_open),
        .m_event_time       (m_event_time),
        .m_transitions      (m_transitions),
        .m_last_confirm_time(m_last_confirm_time),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .fail_count         (fail_count),
        .pending            (pending)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Leave cfg_valid high; the caller drops it after the last write of a group
    task automatic write_reg(input logic [tcd_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [tcd_pkg::CFG_DATA_WIDTH-1:0]  val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge aclk); while (!cfg_ready);
        @(posedge aclk);
    endtask

    task automatic set_config(input bit [15:0] hold, input bit [15:0] open_word);
        write_reg(tcd_pkg::REG_DEBOUNCE_TIME, hold);
        write_reg(tcd_pkg::REG_OPEN_ON_HIGH, open_word);
        // an index past the register list must change nothing
        write_reg(tcd_pkg::CFG_INDEX_WIDTH'(tcd_pkg::REG_OPEN_ON_HIGH + 1
                                            + $urandom_range(0, 253)),
                  tcd_pkg::CFG_DATA_WIDTH'($urandom()));
        cfg_valid <= 1'b0;
        db_ms = hold;
    endtask

    task automatic send_sample(input bit [31:0] t, input bit lvl);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_sample_time <= t;
        s_raw_input   <= lvl;
        now_ms = t;
        sent_count++;
        do @(negedge aclk); while (!s_ready);
        @(posedge aclk);
    endtask

    task automatic wait_results;
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending != 0);
        repeat (2) @(posedge aclk);
    endtask

    // Mostly bounce-then-hold presses; the rest is noise and presses released too early
    task automatic run_random(input int count);
        int        first;
        int        pick;
        bit        tgt;
        bit [31:0] t0;
        first = sent_count;
        while (sent_count - first < count) begin
            pick = $urandom_range(0, 9);
            tgt  = ~lvl_guess;
            if (pick < 7) begin
                repeat ($urandom_range(0, 3))
                    send_sample(now_ms + $urandom_range(0, db_ms / 4 + 1),
                                1'($urandom_range(0, 1)));
                send_sample(now_ms + $urandom_range(1, db_ms / 4 + 1), tgt);
                t0 = now_ms;
                if (db_ms > 0 && $urandom_range(0, 1))
                    send_sample(t0 + db_ms - 1, tgt);
                send_sample(t0 + db_ms + $urandom_range(0, 1), tgt);
                repeat ($urandom_range(0, 2))
                    send_sample(now_ms + $urandom_range(0, db_ms + 3), tgt);
                lvl_guess = tgt;
            end else if (pick == 7) begin
                repeat ($urandom_range(1, 4))
                    send_sample($urandom(), 1'($urandom_range(0, 1)));
            end else begin
                send_sample(now_ms + $urandom_range(1, 5), tgt);
                if (db_ms > 0)
                    send_sample(now_ms + $urandom_range(0, db_ms - 1), tgt);
                send_sample(now_ms + 1, ~tgt);
            end
        end
    endtask

    initial begin
        int phase;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero hold time: seeding, restart-only level change, wrap of the time stamp
        set_config(16'd0, 16'h0000);
        send_sample(32'hFFFF_FFF0, 1'b1);
        send_sample(32'hFFFF_FFF1, 1'b1);
        send_sample(32'hFFFF_FFF8, 1'b0);
        send_sample(32'hFFFF_FFF8, 1'b0);
        send_sample(32'h0000_0003, 1'b1);
        send_sample(32'h0000_0005, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b1);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        wait_results;

        // short hold across the wrap, then a release before the hold time
        set_config(16'd10, 16'hFFFF);
        send_sample(32'hFFFF_FFFA, 1'b1);
        send_sample(32'h0000_0002, 1'b1);
        send_sample(32'h0000_0003, 1'b1);
        send_sample(32'h0000_0004, 1'b1);
        send_sample(32'h0000_0005, 1'b0);
        send_sample(32'h0000_000E, 1'b0);
        send_sample(32'h0000_000F, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);
        wait_results;

        // longest hold: one short of it, exactly at it, and a held time near 2^32
        set_config(16'hFFFF, 16'hFFFE);
        send_sample(32'd100, 1'b0);
        send_sample(32'd100 + 32'd65534, 1'b0);
        send_sample(32'd100 + 32'd65535, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b1);
        lvl_guess = 1'b1;

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_results;
            case (phase)
                0: begin
                    set_config(16'd0, 16'h0000);
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    set_config(16'hFFFF, 16'h0001);
                    idle_pct = 73;
                    stall_pct <= 0;
                end
                2: begin
                    set_config(16'($urandom_range(1, 40)), 16'h0000);
                    idle_pct = 0;
                    stall_pct <= 73;
                end
                3: begin
                    set_config(16'($urandom_range(0, 1000)), 16'h0001);
                    idle_pct = 33;
                    stall_pct <= 33;
                end
                4: begin
                    set_config(16'd3, 16'($urandom_range(0, 1)));
                    idle_pct = 0;
                    stall_pct <= 0;
                end
                default: begin
                    set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                    idle_pct = 33;
                    stall_pct <= 33;
                end
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        wait_results;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
